>>> rtl/core/ima_adpcm_encoder_top_assert.svh
// Assertion macros for the IMA ADPCM encoder.
`ifndef IMA_ADPCM_ENCODER_TOP_ASSERT_SVH
`define IMA_ADPCM_ENCODER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define IMAENC_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define IMAENC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/imaenc_pkg.sv
// Constants, tables and types shared by the IMA ADPCM encoder.
package imaenc_pkg;

   localparam int SAMPLE_W = 16;
   localparam int STEP_W   = 15;
   localparam int INDEX_W  = 7;
   localparam int CODE_W   = 4;
   localparam int BYTE_W   = 8;
   localparam int MAG_W    = SAMPLE_W + 1;
   localparam int NEXT_W   = SAMPLE_W + 2;
   localparam int ADJ_W    = 5;

   localparam logic [INDEX_W-1:0] INDEX_MAX = 7'd88;
   localparam int STEP_COUNT  = 89;
   localparam int STATE_DEPTH = 1;

   localparam logic signed [SAMPLE_W-1:0] PRED_MAX = 16'sh7FFF;
   localparam logic signed [SAMPLE_W-1:0] PRED_MIN = 16'sh8000;

   localparam logic [STEP_W-1:0] STEP_TABLE [STEP_COUNT] = '{
      15'd7,     15'd8,     15'd9,     15'd10,    15'd11,    15'd12,    15'd13,
      15'd14,    15'd16,    15'd17,    15'd19,    15'd21,    15'd23,    15'd25,
      15'd28,    15'd31,    15'd34,    15'd37,    15'd41,    15'd45,    15'd50,
      15'd55,    15'd60,    15'd66,    15'd73,    15'd80,    15'd88,    15'd97,
      15'd107,   15'd118,   15'd130,   15'd143,   15'd157,   15'd173,   15'd190,
      15'd209,   15'd230,   15'd253,   15'd279,   15'd307,   15'd337,   15'd371,
      15'd408,   15'd449,   15'd494,   15'd544,   15'd598,   15'd658,   15'd724,
      15'd796,   15'd876,   15'd963,   15'd1060,  15'd1166,  15'd1282,  15'd1411,
      15'd1552,  15'd1707,  15'd1878,  15'd2066,  15'd2272,  15'd2499,  15'd2749,
      15'd3024,  15'd3327,  15'd3660,  15'd4026,  15'd4428,  15'd4871,  15'd5358,
      15'd5894,  15'd6484,  15'd7132,  15'd7845,  15'd8630,  15'd9493,  15'd10442,
      15'd11487, 15'd12635, 15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350,
      15'd22385, 15'd24623, 15'd27086, 15'd29794, 15'd32767
   };

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] predictor;
      logic [INDEX_W-1:0]         step_index;
      logic [CODE_W-1:0]          held_nibble;
      logic                       nibble_pending;
   } state_type;

   localparam int STATE_W = $bits(state_type);

   // Index adjust depends only on the magnitude bits of the code.
   function automatic logic signed [ADJ_W-1:0] index_adjust(input logic [CODE_W-2:0] mag);
      logic signed [ADJ_W-1:0] adj;
      case (mag)
         3'd4:    adj = 5'sd2;
         3'd5:    adj = 5'sd4;
         3'd6:    adj = 5'sd6;
         3'd7:    adj = 5'sd8;
         default: adj = -5'sd1;
      endcase
      return adj;
   endfunction

endpackage

>>> rtl/core/imaenc_ram.sv
// Generic simple dual-port RAM (one write port, one read port) with registered read.
module imaenc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/ima_adpcm_encoder_top.sv
// IMA ADPCM encoder: 16-bit PCM samples in, packed 4-bit codes out two per byte.
//
// Input channel (req_): one signed sample per word, with req_last marking the
// final sample of a block. Output channel (rsp_): one packed byte per two
// samples, earlier code in the low nibble; a block ending on an odd sample
// flushes a byte with a zero high nibble, and rsp_block_end flags the last byte.
// A word is taken on a rising edge with valid high and stall low.
//
// A new sample is taken only while the lookup stage is empty and any sample in
// the quantize stage moves on. The predictor/index/nibble state sits in a
// one-entry RAM; each sample reads it, looks up the step (registered), then
// quantizes and writes the state back, so the next sample can start its read in
// the write-back cycle and takes the new state by forwarding. An accepted sample
// passes the lookup and quantize registers before its byte reaches rsp_valid.
//
// Reset clears the pipeline and makes the state read as zero until written.
// A stalled byte holds in the output register; the encoder keeps taking samples
// until a finished byte waits in the quantize stage, then stalls req_.
module ima_adpcm_encoder_top
   import imaenc_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  logic                       req_last,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [BYTE_W-1:0]          rsp_packed_byte,
   output logic                       rsp_block_end
);

   // Pipeline control
   logic b_valid_ff, b_valid_in;
   logic c_valid_ff, c_valid_in;
   logic out_valid_ff, out_valid_in;
   logic init_ff, init_in;
   logic rd_init_ff, rd_init_in;
   logic fwd_ff, fwd_in;

   // Payload
   logic signed [SAMPLE_W-1:0] b_sample_ff, c_sample_ff;
   logic                       b_last_ff, c_last_ff;
   state_type                  c_state_ff, wb_state_ff;
   logic [STEP_W-1:0]          c_step_ff;
   logic [BYTE_W-1:0]          out_byte_ff;
   logic                       out_end_ff;

   logic      accept;
   logic      c_emit;
   logic      c_go;
   state_type ram_q;
   state_type b_state;
   state_type c_next;
   logic [INDEX_W-1:0] b_index;

   logic signed [MAG_W-1:0]  diff;
   logic                     neg;
   logic [MAG_W-1:0]         mag0, mag1, mag2;
   logic [MAG_W-1:0]         step_x, half_x, qtr_x, delta;
   logic                     b2, b1, b0;
   logic signed [NEXT_W-1:0] pred_x, next_pred;
   logic signed [SAMPLE_W-1:0] pred_sat;
   logic [CODE_W-1:0]        code;
   logic signed [INDEX_W:0]  next_index;
   logic [INDEX_W-1:0]       index_sat;
   logic [BYTE_W-1:0]        c_byte;

   // ---------------- handshake ----------------
   assign c_emit    = c_state_ff.nibble_pending | c_last_ff;
   assign c_go      = c_valid_ff & (~c_emit | ~out_valid_ff | ~rsp_stall);
   // Take a sample only when its state read cannot miss a pending write-back.
   assign req_stall = b_valid_ff | (c_valid_ff & ~c_go);
   assign accept    = req_valid & ~req_stall;

   // ---------------- state memory ----------------
   imaenc_ram #(
      .WIDTH (STATE_W),
      .DEPTH (STATE_DEPTH)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (c_go),
      .wr_addr (1'b0),
      .wr_data (c_next),
      .rd_en   (accept),
      .rd_addr (1'b0),
      .rd_data (ram_q)
   );

   // ---------------- stage B: state select, step lookup ----------------
   always_comb begin
      if (fwd_ff) begin
         b_state = wb_state_ff;
      end else if (rd_init_ff) begin
         b_state = ram_q;
      end else begin
         b_state = '0;
      end
      b_index = (b_state.step_index > INDEX_MAX) ? INDEX_MAX : b_state.step_index;
   end

   // ---------------- stage C: quantize and update ----------------
   always_comb begin
      diff   = MAG_W'(c_sample_ff) - MAG_W'(c_state_ff.predictor);
      neg    = diff[MAG_W-1];
      mag0   = neg ? (~diff + 1'b1) : diff;
      step_x = MAG_W'(c_step_ff);
      half_x = MAG_W'(c_step_ff >> 1);
      qtr_x  = MAG_W'(c_step_ff >> 2);
      b2     = (mag0 >= step_x);
      mag1   = b2 ? (mag0 - step_x) : mag0;
      b1     = (mag1 >= half_x);
      mag2   = b1 ? (mag1 - half_x) : mag1;
      b0     = (mag2 >= qtr_x);
      delta  = MAG_W'(c_step_ff >> 3) + (b2 ? step_x : '0) + (b1 ? half_x : '0)
             + (b0 ? qtr_x : '0);
      code   = {neg, b2, b1, b0};

      pred_x    = NEXT_W'(c_state_ff.predictor);
      next_pred = neg ? (pred_x - $signed({1'b0, delta})) : (pred_x + $signed({1'b0, delta}));
      if (next_pred > NEXT_W'(PRED_MAX)) begin
         pred_sat = PRED_MAX;
      end else if (next_pred < NEXT_W'(PRED_MIN)) begin
         pred_sat = PRED_MIN;
      end else begin
         pred_sat = next_pred[SAMPLE_W-1:0];
      end

      next_index = $signed({1'b0, c_state_ff.step_index}) + (INDEX_W + 1)'(index_adjust(code[2:0]));
      if (next_index < 0) begin
         index_sat = '0;
      end else if (next_index > $signed({1'b0, INDEX_MAX})) begin
         index_sat = INDEX_MAX;
      end else begin
         index_sat = next_index[INDEX_W-1:0];
      end

      c_next.predictor  = pred_sat;
      c_next.step_index = index_sat;
      if (c_state_ff.nibble_pending) begin
         c_next.held_nibble    = '0;
         c_next.nibble_pending = 1'b0;
         c_byte                = {code, c_state_ff.held_nibble};
      end else if (c_last_ff) begin
         c_next.held_nibble    = c_state_ff.held_nibble;
         c_next.nibble_pending = 1'b0;
         c_byte                = {{CODE_W{1'b0}}, code};
      end else begin
         c_next.held_nibble    = code;
         c_next.nibble_pending = 1'b1;
         c_byte                = {{CODE_W{1'b0}}, code};
      end
   end

   // ---------------- control next values ----------------
   always_comb begin
      b_valid_in = accept;
      c_valid_in = b_valid_ff | (c_valid_ff & ~c_go);
      init_in    = init_ff | c_go;
      rd_init_in = accept ? init_ff : rd_init_ff;
      fwd_in     = accept ? c_go : fwd_ff;
      if (c_go & c_emit) begin
         out_valid_in = 1'b1;
      end else if (out_valid_ff & ~rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
         init_ff      <= 1'b0;
         rd_init_ff   <= 1'b0;
         fwd_ff       <= 1'b0;
      end else begin
         b_valid_ff   <= b_valid_in;
         c_valid_ff   <= c_valid_in;
         out_valid_ff <= out_valid_in;
         init_ff      <= init_in;
         rd_init_ff   <= rd_init_in;
         fwd_ff       <= fwd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         b_sample_ff <= req_sample;
         b_last_ff   <= req_last;
      end
      if (b_valid_ff) begin
         c_sample_ff <= b_sample_ff;
         c_last_ff   <= b_last_ff;
         c_state_ff  <= {b_state.predictor, b_index, b_state.held_nibble,
                         b_state.nibble_pending};
         c_step_ff   <= STEP_TABLE[b_index];
      end
      if (c_go) begin
         wb_state_ff <= c_next;
      end
      if (c_go & c_emit) begin
         out_byte_ff <= c_byte;
         out_end_ff  <= c_last_ff;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_packed_byte = out_byte_ff;
   assign rsp_block_end   = out_end_ff;

   // ---------------- assertions ----------------
`include "ima_adpcm_encoder_top_assert.svh"

   `IMAENC_ASSERT_NOW(a_b_implies_c_empty, b_valid_ff, !c_valid_ff, "lookup stage overlaps quantize stage")
   `IMAENC_ASSERT_NEXT(a_accept_to_b, accept, b_valid_ff, "accepted word did not enter lookup stage")
   `IMAENC_ASSERT_NOW(a_index_range, c_valid_ff, c_state_ff.step_index <= INDEX_MAX, "step index above table end")
   `IMAENC_ASSERT_NEXT(a_wb_range, c_go, wb_state_ff.step_index <= INDEX_MAX, "written step index out of range")

endmodule
